FILE: hw/rtl/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int VERTEX_COUNT_DEF = 1024;
  localparam int SUM_W            = 40;
  localparam int ROOT_W           = 31;
  localparam int RAD_W            = 62;
  localparam logic signed [15:0] UP_ONE = 16'sd16384;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TRI   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [9:0]         index_a;
    logic [9:0]         index_b;
    logic [9:0]         index_c;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic               degenerate;
  } out_word_t;

endpackage

FILE: hw/rtl/vna_isqrt.sv
// ----------------------------------------------------------------------------
// vna_isqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vna_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [vna_pkg::RAD_W-1:0]   radicand,
  output logic                        done,
  output logic [vna_pkg::ROOT_W-1:0]  root
);
  import vna_pkg::*;

  logic [62:0] v_r, res_r, bit_r;
  logic [62:0] v_nxt, res_nxt, trial;
  logic        busy_r;

  // one digit step of the restoring root
  always_comb begin
    trial = res_r + bit_r;
    if (v_r >= trial) begin
      v_nxt   = v_r - trial;
      res_nxt = (res_r >> 1) + bit_r;
    end else begin
      v_nxt   = v_r;
      res_nxt = res_r >> 1;
    end
  end

  assign done = busy_r && bit_r[0];
  assign root = res_nxt[ROOT_W-1:0];

  // hold the busy flag across the sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  // advance the remainder, root and weight
  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= {1'b0, radicand};
      res_r <= '0;
      bit_r <= 63'(1) << 62;
    end else if (busy_r) begin
      v_r   <= v_nxt;
      res_r <= res_nxt;
      bit_r <= bit_r >> 2;
    end
  end

endmodule

FILE: hw/rtl/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Area-weighted vertex normals: positions and sums in memories with one write and one read port.
// ----------------------------------------------------------------------------
// Load and clear are single writes; a triangle runs three position reads,
// six products on the shared multiplier and three sum read-modify-writes.
// A read runs the 32-step root and three 15-step divisions; the block works
// on one word at a time.
// After reset the sum memory is swept to zero, with the input stalled.
// Positions are not cleared.
module vertex_normal_accumulator #(
  parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vna_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vna_pkg::out_word_t  out_data
);
  import vna_pkg::*;

  localparam int AW = $clog2(VERTEX_COUNT);
  localparam logic [16:0]   VC_W      = 17'(VERTEX_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(VERTEX_COUNT - 1);

  typedef enum logic [11:0] {
    S_CLR  = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_PRD  = 12'b000000000100,
    S_MUL  = 12'b000000001000,
    S_SRD  = 12'b000000010000,
    S_SUPD = 12'b000000100000,
    S_NRD  = 12'b000001000000,
    S_SQ   = 12'b000010000000,
    S_SQRT = 12'b000100000000,
    S_DINI = 12'b001000000000,
    S_DIV  = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  function automatic logic in_rng(input logic [9:0] idx);
    return {7'd0, idx} < VC_W;
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [9:0] idx);
    logic [16:0] e;
    e = {7'd0, idx};
    return e[AW-1:0];
  endfunction

  function automatic logic signed [39:0] sat_add(input logic signed [39:0] s,
                                                 input logic signed [34:0] c);
    logic signed [40:0] t;
    t = 41'(s) + 41'(c);
    if (t[40] != t[39]) begin
      return t[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end
    return t[39:0];
  endfunction

  state_t             state_r, state_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]      clr_addr_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_r, res_r;
  in_word_t           item_r;
  logic               accept;
  logic               up_result;

  // position memory
  logic [47:0]   pos_mem [VERTEX_COUNT];
  logic          pos_we;
  logic [AW-1:0] pos_waddr, pos_raddr;
  logic [47:0]   pos_wdata, pos_rdata_r;

  // sum memory, {z, y, x}
  logic [119:0]  sum_mem [VERTEX_COUNT];
  logic          sum_we;
  logic [AW-1:0] sum_waddr, sum_raddr, corner_addr;
  logic [119:0]  sum_wdata, sum_rdata_r;

  // datapath
  logic signed [15:0] pa_x_r, pa_y_r, pa_z_r;
  logic signed [16:0] e1_x_r, e1_y_r, e1_z_r, e2_x_r, e2_y_r, e2_z_r;
  logic signed [16:0] d_x, d_y, d_z;
  logic signed [34:0] cx_r, cy_r, cz_r;
  logic signed [30:0] mul_a, mul_b;
  logic signed [61:0] prod_r;
  logic [29:0]        mx_r, my_r, mz_r, m_sel;
  logic [2:0]         neg_r;
  logic               neg_sel;
  logic [61:0]        sumsq_r;
  logic [30:0]        len_r;
  logic [46:0]        dn_r, dd_r;
  logic [14:0]        dq_r, q_fin;
  logic [3:0]         dstep_r;
  logic               q_bit;
  logic signed [15:0] comp_val;

  // normalise front end
  logic signed [39:0] sx, sy, sz;
  logic [39:0]        ax, ay, az, a_or;
  logic [3:0]         shift_k;

  // root unit
  logic               sq_start, sq_done;
  logic [RAD_W-1:0]   sq_rad;
  logic [ROOT_W-1:0]  sq_root;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign up_result = (state_r == S_NRD) && (sum_rdata_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_CLR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cnt_nxt = 3'd0;
        if (in_valid) begin
          case (in_data.command)
            CMD_TRI: begin
              if (in_rng(in_data.index_a) && in_rng(in_data.index_b) &&
                  in_rng(in_data.index_c)) state_nxt = S_PRD;
            end
            CMD_READ: begin
              state_nxt = in_rng(in_data.index_a) ? S_NRD : S_OUT;
            end
            default: ;
          endcase
        end
      end
      S_PRD: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          state_nxt = S_MUL;
          cnt_nxt   = 3'd0;
        end
      end
      S_MUL: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd6) begin
          state_nxt = S_SRD;
          cnt_nxt   = 3'd0;
        end
      end
      S_SRD: state_nxt = S_SUPD;
      S_SUPD: begin
        if (cnt_r == 3'd2) begin
          state_nxt = S_IDLE;
          cnt_nxt   = 3'd0;
        end else begin
          state_nxt = S_SRD;
          cnt_nxt   = cnt_r + 3'd1;
        end
      end
      S_NRD: begin
        state_nxt = up_result ? S_OUT : S_SQ;
        cnt_nxt   = 3'd0;
      end
      S_SQ: begin
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          state_nxt = S_SQRT;
          cnt_nxt   = 3'd0;
        end
      end
      S_SQRT: begin
        if (sq_done) state_nxt = S_DINI;
      end
      S_DINI: state_nxt = S_DIV;
      S_DIV: begin
        if (dstep_r == 4'd14) begin
          if (cnt_r == 3'd2) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DINI;
            cnt_nxt   = cnt_r + 3'd1;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold a stalled word, load a finished one
  assign out_valid_nxt = (out_valid_r && out_stall) || (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= 3'd0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLR) clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && !(out_valid_r && out_stall)) out_r <= res_r;
  end

  // memory ports
  always_comb begin
    case (cnt_r)
      3'd0:    corner_addr = to_addr(item_r.index_a);
      3'd1:    corner_addr = to_addr(item_r.index_b);
      default: corner_addr = to_addr(item_r.index_c);
    endcase
  end

  assign pos_we    = accept && (in_data.command == CMD_LOAD) && in_rng(in_data.index_a);
  assign pos_waddr = to_addr(in_data.index_a);
  assign pos_wdata = {in_data.pos_z, in_data.pos_y, in_data.pos_x};
  assign pos_raddr = corner_addr;

  assign sum_we = (state_r == S_CLR) || (state_r == S_SUPD) ||
                  (accept && (in_data.command == CMD_CLEAR) && in_rng(in_data.index_a));
  assign sum_waddr = (state_r == S_CLR)  ? clr_addr_r :
                     (state_r == S_SUPD) ? corner_addr : to_addr(in_data.index_a);
  assign sum_raddr = (state_r == S_IDLE) ? to_addr(in_data.index_a) : corner_addr;
  assign sum_wdata = (state_r == S_SUPD) ?
                     {sat_add(sum_rdata_r[119:80], cz_r),
                      sat_add(sum_rdata_r[79:40], cy_r),
                      sat_add(sum_rdata_r[39:0], cx_r)} : '0;

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rdata_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    sum_rdata_r <= sum_mem[sum_raddr];
  end

  // edge vectors from the word just read
  assign d_x = {pos_rdata_r[15], pos_rdata_r[15:0]}  - {pa_x_r[15], pa_x_r};
  assign d_y = {pos_rdata_r[31], pos_rdata_r[31:16]} - {pa_y_r[15], pa_y_r};
  assign d_z = {pos_rdata_r[47], pos_rdata_r[47:32]} - {pa_z_r[15], pa_z_r};

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == S_SQ) begin
      case (cnt_r)
        3'd0:    begin mul_a = {1'b0, mx_r}; mul_b = {1'b0, mx_r}; end
        3'd1:    begin mul_a = {1'b0, my_r}; mul_b = {1'b0, my_r}; end
        default: begin mul_a = {1'b0, mz_r}; mul_b = {1'b0, mz_r}; end
      endcase
    end else begin
      case (cnt_r)
        3'd0:    begin mul_a = 31'(e1_y_r); mul_b = 31'(e2_z_r); end
        3'd1:    begin mul_a = 31'(e1_z_r); mul_b = 31'(e2_y_r); end
        3'd2:    begin mul_a = 31'(e1_z_r); mul_b = 31'(e2_x_r); end
        3'd3:    begin mul_a = 31'(e1_x_r); mul_b = 31'(e2_z_r); end
        3'd4:    begin mul_a = 31'(e1_x_r); mul_b = 31'(e2_y_r); end
        default: begin mul_a = 31'(e1_y_r); mul_b = 31'(e2_x_r); end
      endcase
    end
  end

  // magnitudes and common shift
  always_comb begin
    sx = sum_rdata_r[39:0];
    sy = sum_rdata_r[79:40];
    sz = sum_rdata_r[119:80];
    ax = sx[39] ? 40'(-sx) : sx;
    ay = sy[39] ? 40'(-sy) : sy;
    az = sz[39] ? 40'(-sz) : sz;
    a_or = ax | ay | az;
    shift_k = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (a_or[30 + i]) shift_k = 4'(i + 1);
    end
  end

  // per-component divider operands
  always_comb begin
    case (cnt_r)
      3'd0:    begin m_sel = mx_r; neg_sel = neg_r[0]; end
      3'd1:    begin m_sel = my_r; neg_sel = neg_r[1]; end
      default: begin m_sel = mz_r; neg_sel = neg_r[2]; end
    endcase
    q_bit    = (dn_r >= dd_r);
    q_fin    = {dq_r[13:0], q_bit};
    comp_val = neg_sel ? 16'(-{1'b0, q_fin}) : {1'b0, q_fin};
  end

  assign sq_start = (state_r == S_SQ) && (cnt_r == 3'd3);
  assign sq_rad   = sumsq_r + 62'(prod_r);

  vna_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (accept) begin
      item_r <= in_data;
      if ((in_data.command == CMD_READ) && !in_rng(in_data.index_a)) begin
        res_r <= '{normal_x: '0, normal_y: UP_ONE, normal_z: '0, degenerate: 1'b1};
      end
    end
    case (state_r)
      S_PRD: begin
        case (cnt_r)
          3'd1: begin
            pa_x_r <= pos_rdata_r[15:0];
            pa_y_r <= pos_rdata_r[31:16];
            pa_z_r <= pos_rdata_r[47:32];
          end
          3'd2: begin e1_x_r <= d_x; e1_y_r <= d_y; e1_z_r <= d_z; end
          3'd3: begin
            e2_x_r <= d_x; e2_y_r <= d_y; e2_z_r <= d_z;
            cx_r <= '0; cy_r <= '0; cz_r <= '0;
          end
          default: ;
        endcase
      end
      S_MUL: begin
        case (cnt_r)
          3'd1:    cx_r <= cx_r + $signed(prod_r[34:0]);
          3'd2:    cx_r <= cx_r - $signed(prod_r[34:0]);
          3'd3:    cy_r <= cy_r + $signed(prod_r[34:0]);
          3'd4:    cy_r <= cy_r - $signed(prod_r[34:0]);
          3'd5:    cz_r <= cz_r + $signed(prod_r[34:0]);
          3'd6:    cz_r <= cz_r - $signed(prod_r[34:0]);
          default: ;
        endcase
      end
      S_NRD: begin
        if (up_result) begin
          res_r <= '{normal_x: '0, normal_y: UP_ONE, normal_z: '0, degenerate: 1'b1};
        end else begin
          res_r.degenerate <= 1'b0;
        end
        mx_r  <= 30'(ax >> shift_k);
        my_r  <= 30'(ay >> shift_k);
        mz_r  <= 30'(az >> shift_k);
        neg_r <= {sz[39], sy[39], sx[39]};
      end
      S_SQ: begin
        if (cnt_r == 3'd1) sumsq_r <= 62'(prod_r);
        if (cnt_r == 3'd2) sumsq_r <= sumsq_r + 62'(prod_r);
      end
      S_SQRT: begin
        if (sq_done) len_r <= sq_root;
      end
      S_DINI: begin
        dn_r    <= 47'({m_sel, 15'd0}) + 47'(len_r);
        dd_r    <= 47'({len_r, 15'd0});
        dq_r    <= '0;
        dstep_r <= 4'd0;
      end
      S_DIV: begin
        if (q_bit) dn_r <= dn_r - dd_r;
        dd_r    <= dd_r >> 1;
        dq_r    <= q_fin;
        dstep_r <= dstep_r + 4'd1;
        if (dstep_r == 4'd14) begin
          case (cnt_r)
            3'd0:    res_r.normal_x <= comp_val;
            3'd1:    res_r.normal_y <= comp_val;
            default: res_r.normal_z <= comp_val;
          endcase
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_clr_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("word accepted during sum clearing sweep");

  a_pos_we_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    pos_we |-> (in_valid && !in_stall && (in_data.command == CMD_LOAD)))
    else $error("position written outside a load");

  a_root_in_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == S_SQRT))
    else $error("root finished outside its state");

  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dstep_r <= 4'd14))
    else $error("divider ran past its last step");
`endif

endmodule
